// ===== rtl/core/clc_pkg.sv =====
package clc_pkg;

  localparam int NUM_ENTRIES = 7;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LEVEL_W     = 8;
  localparam int CNT_W       = 10;
  localparam int SYM_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int PROD_W      = 2 * LEVEL_W;
  localparam int TOL_SHIFT   = 11;
  localparam int TOL_W       = PROD_W - TOL_SHIFT;

  // Multiplying by 205 and dropping 11 bits gives an exact floor of one tenth over 8 bits.
  localparam logic [LEVEL_W-1:0] TOL_MUL = 8'd205;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_WINDOW = 2'd2;

  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST    = 8'd10;
  localparam logic [CNT_W-1:0]   LONG_PRESS_RST   = 10'd200;
  localparam logic [CNT_W-1:0]   ENTRY_WINDOW_RST = 10'd200;

  localparam logic [SYM_W-1:0] SYM_DASH    = 4'd7;
  localparam logic [SYM_W-1:0] SYM_UNKNOWN = 4'd8;
  localparam logic [SYM_W-1:0] SYM_BLANK   = 4'd9;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t [NUM_ENTRIES-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    MODE_WINDOW = 3'b001,
    MODE_RUN    = 3'b010,
    MODE_CAL    = 3'b100
  } mode_t;

  typedef struct packed {
    logic classify;
    logic done;
    logic dash;
    logic write_en;
    logic sel_none;
    idx_t sel;
  } op_t;

  function automatic idx_t next_sel(input logic none, input idx_t cur);
    idx_t res;
    res = IDX_W'(1);
    if (none) begin
      res = IDX_W'(1);
    end else if (cur == IDX_W'(1)) begin
      res = IDX_W'(0);
    end else if (cur == IDX_W'(0)) begin
      if (NUM_ENTRIES > 2) begin
        res = IDX_W'(2);
      end
    end else if (({1'b0, cur} + (IDX_W+1)'(1)) < (IDX_W+1)'(NUM_ENTRIES)) begin
      res = cur + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/clc_table.sv =====
module clc_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic            wr_en,
  input  clc_pkg::idx_t   wr_idx,
  input  clc_pkg::level_t wr_val,
  output clc_pkg::row_t   row
);
  import clc_pkg::*;

  row_t mem [1];
  row_t rdata;
  row_t wr_row;
  row_t fwd_row;
  logic fwd_valid;
  logic written;
  logic rd_written;

  // The row written at the same edge as the read is not yet in rdata, so it is forwarded.
  always_comb begin
    if (fwd_valid) begin
      row = fwd_row;
    end else if (rd_written) begin
      row = rdata;
    end else begin
      row = '0;
    end
  end

  always_comb begin
    wr_row = row;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (wr_idx == IDX_W'(i)) begin
        wr_row[i] = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[0] <= wr_row;
    end
    if (rd_en) begin
      rdata   <= mem[0];
      fwd_row <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= 1'b0;
      rd_written <= 1'b0;
      fwd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        written <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written;
        fwd_valid  <= wr_en;
      end
    end
  end

endmodule

// ===== rtl/core/clc_ctrl.sv =====
module clc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic                            cmd,
  input  clc_pkg::level_t                 sample,
  input  logic                            button_level,
  output clc_pkg::op_t                    op
);
  import clc_pkg::*;

  level_t           min_level;
  logic [CNT_W-1:0] long_press;
  logic [CNT_W-1:0] entry_window;

  mode_t            mode, mode_next;
  logic [CNT_W-1:0] window_count, window_count_next;
  logic [CNT_W-1:0] press_count, press_count_next;
  logic             press_active, press_active_next;
  logic             sel_none, sel_none_next;
  idx_t             sel, sel_next;

  always_comb begin
    mode_next         = mode;
    window_count_next = window_count;
    press_count_next  = press_count;
    press_active_next = press_active;
    sel_none_next     = sel_none;
    sel_next          = sel;
    op                = '0;

    if (cmd) begin
      mode_next         = MODE_CAL;
      sel_none_next     = 1'b0;
      sel_next          = IDX_W'(1);
      press_active_next = 1'b0;
      press_count_next  = '0;
    end

    if (mode_next == MODE_WINDOW) begin
      if (window_count >= entry_window) begin
        mode_next = MODE_RUN;
      end else if (button_level) begin
        mode_next         = MODE_CAL;
        sel_none_next     = 1'b1;
        press_active_next = 1'b0;
        press_count_next  = '0;
      end else begin
        window_count_next = window_count + CNT_W'(1);
      end
    end

    op.dash     = (sample <= min_level);
    op.classify = 1'b1;

    if (mode_next == MODE_CAL) begin
      op.classify = 1'b0;
      if (button_level) begin
        if (!press_active_next) begin
          press_active_next = 1'b1;
          press_count_next  = '0;
        end
        if (press_count_next != CNT_MAX) begin
          press_count_next = press_count_next + CNT_W'(1);
        end
        if (press_count_next >= long_press) begin
          mode_next         = MODE_RUN;
          press_active_next = 1'b0;
          press_count_next  = '0;
          op.classify       = 1'b1;
          op.done           = 1'b1;
        end
      end else if (press_active_next) begin
        sel_next          = next_sel(sel_none_next, sel_next);
        sel_none_next     = 1'b0;
        press_active_next = 1'b0;
      end
      op.write_en = !op.done && !sel_none_next;
    end

    op.sel      = sel_next;
    op.sel_none = sel_none_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_WINDOW;
      window_count <= '0;
      press_count  <= '0;
      press_active <= 1'b0;
      sel_none     <= 1'b1;
      sel          <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      window_count <= window_count_next;
      press_count  <= press_count_next;
      press_active <= press_active_next;
      sel_none     <= sel_none_next;
      sel          <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level    <= MIN_LEVEL_RST;
      long_press   <= LONG_PRESS_RST;
      entry_window <= ENTRY_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LEVEL:    min_level    <= cfg_data[LEVEL_W-1:0];
        CFG_LONG_PRESS:   long_press   <= cfg_data[CNT_W-1:0];
        CFG_ENTRY_WINDOW: entry_window <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/clc_classify.sv =====
module clc_classify (
  input  clc_pkg::row_t               row,
  input  clc_pkg::level_t             lo,
  input  logic [clc_pkg::LEVEL_W:0]   hi,
  input  logic                        dash,
  output logic [clc_pkg::SYM_W-1:0]   symbol
);
  import clc_pkg::*;

  logic             hit;
  logic [SYM_W-1:0] hit_sym;

  // Ascending scan so the highest matching entry wins.
  always_comb begin
    hit     = 1'b0;
    hit_sym = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if ((row[i] > lo) && ({1'b0, row[i]} < hi)) begin
        hit     = 1'b1;
        hit_sym = SYM_W'(i);
      end
    end
  end

  always_comb begin
    priority if (dash) begin
      symbol = SYM_DASH;
    end else if (hit) begin
      symbol = hit_sym;
    end else begin
      symbol = SYM_UNKNOWN;
    end
  end

endmodule

// ===== rtl/core/calibrated_level_classifier.sv =====
// Calibrated level classifier: maps each sensor sample to a display symbol.
// Input channel: in_valid, in_stall and the fields cmd, sample and button_level.
// A transfer takes place at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall and the fields symbol, calibrating and
// calibration_done; every input transfer yields exactly one output transfer.
// Configuration: cfg_we, cfg_index and cfg_data write min_level (0),
// long_press_ticks (1) and entry_window_ticks (2); other indexes are ignored.
// Each item is registered in stage s1 at its input transfer and loaded into the
// output register when s1 advances. Throughput: one item per cycle while no
// out_stall holds the output. The calibration table is one memory row that is
// read at the input transfer and written back as the item moves on; the row
// written at the edge of a read is forwarded, so items can follow back to back.
// When out_stall holds the output register, the stage behind it keeps its item
// and in_stall rises once both are full; no result is lost or repeated.
// Reset (rst, synchronous) returns to the start-up window with nothing selected,
// loads the register defaults and makes the table read as all zeros.
module calibrated_level_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [clc_pkg::LEVEL_W-1:0]     sample,
  input  logic                            button_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clc_pkg::SYM_W-1:0]       symbol,
  output logic                            calibrating,
  output logic                            calibration_done
);
  import clc_pkg::*;

  logic              accept;
  logic              out_free;
  logic              s1_adv;
  op_t               op;
  logic [PROD_W-1:0] tol_prod;
  logic [TOL_W-1:0]  tol;
  level_t            lo;
  logic [LEVEL_W:0]  hi;

  logic              s1_valid;
  op_t               s1_op;
  level_t            s1_sample;
  level_t            s1_lo;
  logic [LEVEL_W:0]  s1_hi;

  row_t              row;
  logic              wr_en;
  logic [SYM_W-1:0]  class_sym;
  logic [SYM_W-1:0]  symbol_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = s1_adv && s1_op.write_en;

  assign tol_prod = PROD_W'(sample) * PROD_W'(TOL_MUL);
  assign tol      = tol_prod[PROD_W-1:TOL_SHIFT];
  assign lo       = sample - LEVEL_W'(tol);
  assign hi       = (LEVEL_W+1)'(sample) + (LEVEL_W+1)'(tol);

  clc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .cmd          (cmd),
    .sample       (sample),
    .button_level (button_level),
    .op           (op)
  );

  clc_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .wr_en  (wr_en),
    .wr_idx (s1_op.sel),
    .wr_val (s1_sample),
    .row    (row)
  );

  clc_classify u_classify (
    .row    (row),
    .lo     (s1_lo),
    .hi     (s1_hi),
    .dash   (s1_op.dash),
    .symbol (class_sym)
  );

  always_comb begin
    priority if (s1_op.classify) begin
      symbol_next = class_sym;
    end else if (s1_op.sel_none) begin
      symbol_next = SYM_BLANK;
    end else begin
      symbol_next = SYM_W'(s1_op.sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= op;
      s1_sample <= sample;
      s1_lo     <= lo;
      s1_hi     <= hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      symbol           <= symbol_next;
      calibrating      <= !s1_op.classify;
      calibration_done <= s1_op.done;
    end
  end

  a_done_ends_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibration_done |-> !calibrating)
    else $error("calibration_done shown together with calibrating");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_write_is_cal: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> out_valid && calibrating)
    else $error("table written by an item that is not a calibration item");

endmodule
